// File: sv/lrcm_pkg.sv
// Shared types, constants and lookup functions for the linear resampler with channel map.
package lrcm_pkg;

  // Fixed data formats
  localparam int MAX_CH          = 8;
  localparam int SAMPLE_BITS     = 24;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int PHASE_BITS      = PHASE_FRAC_BITS + 5;
  localparam int CH_CNT_BITS     = 4;
  localparam int RESULT_CAP      = 16;
  localparam int RUN_CNT_BITS    = $clog2(RESULT_CAP + 1);

  // Datapath widths
  localparam int DIFF_BITS  = SAMPLE_BITS + 1;
  localparam int PROD_BITS  = DIFF_BITS + PHASE_FRAC_BITS + 1;
  localparam int SUM_BITS   = SAMPLE_BITS + $clog2(MAX_CH);
  localparam int DIV_SHIFT  = SUM_BITS + $clog2(MAX_CH);
  localparam int RECIP_BITS = DIV_SHIFT + 1;
  localparam int DIVP_BITS  = SUM_BITS + RECIP_BITS;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = PHASE_BITS;

  // Input queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(64'd1 << PHASE_FRAC_BITS);
  localparam logic [PHASE_BITS-1:0] PHASE_MAX = '1;
  localparam logic [PHASE_BITS-1:0] STEP_RESET = PHASE_ONE;
  localparam logic [CH_CNT_BITS-1:0] CH_RESET = CH_CNT_BITS'(2);

  // Reciprocals ceil(2^DIV_SHIFT / n), exact for truncating division of |sum| by n
  localparam logic [RECIP_BITS-1:0] RECIP_1 = RECIP_BITS'((64'd1 << DIV_SHIFT));
  localparam logic [RECIP_BITS-1:0] RECIP_2 = RECIP_BITS'(((64'd1 << DIV_SHIFT) + 1) / 2);
  localparam logic [RECIP_BITS-1:0] RECIP_3 = RECIP_BITS'(((64'd1 << DIV_SHIFT) + 2) / 3);
  localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'(((64'd1 << DIV_SHIFT) + 3) / 4);
  localparam logic [RECIP_BITS-1:0] RECIP_5 = RECIP_BITS'(((64'd1 << DIV_SHIFT) + 4) / 5);
  localparam logic [RECIP_BITS-1:0] RECIP_6 = RECIP_BITS'(((64'd1 << DIV_SHIFT) + 5) / 6);
  localparam logic [RECIP_BITS-1:0] RECIP_7 = RECIP_BITS'(((64'd1 << DIV_SHIFT) + 6) / 7);
  localparam logic [RECIP_BITS-1:0] RECIP_8 = RECIP_BITS'(((64'd1 << DIV_SHIFT) + 7) / 8);

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STEP_RATIO   = 2'd0,
    CFG_IN_CHANNELS  = 2'd1,
    CFG_OUT_CHANNELS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0]  step;
    logic [CH_CNT_BITS-1:0] nin;
    logic [CH_CNT_BITS-1:0] nout;
  } cfg_t;

  typedef logic [MAX_CH-1:0][SAMPLE_BITS-1:0] frame_t;

  // One queued input frame; prime marks the very first frame (stored, no output)
  typedef struct packed {
    logic   prime;
    frame_t frame;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_MIX,
    BK_SUM,
    BK_DIV,
    BK_OUT
  } bk_state_t;

  // Zero counts as one, anything above MAX_CH as MAX_CH
  function automatic logic [CH_CNT_BITS-1:0] clamp_count(input logic [CH_CNT_BITS-1:0] n);
    logic [CH_CNT_BITS-1:0] r;
    if (n == '0) begin
      r = CH_CNT_BITS'(1);
    end else if (n > CH_CNT_BITS'(MAX_CH)) begin
      r = CH_CNT_BITS'(MAX_CH);
    end else begin
      r = n;
    end
    return r;
  endfunction

  function automatic logic [RECIP_BITS-1:0] recip(input logic [CH_CNT_BITS-1:0] n);
    logic [RECIP_BITS-1:0] r;
    unique case (n)
      CH_CNT_BITS'(2): r = RECIP_2;
      CH_CNT_BITS'(3): r = RECIP_3;
      CH_CNT_BITS'(4): r = RECIP_4;
      CH_CNT_BITS'(5): r = RECIP_5;
      CH_CNT_BITS'(6): r = RECIP_6;
      CH_CNT_BITS'(7): r = RECIP_7;
      CH_CNT_BITS'(8): r = RECIP_8;
      default:         r = RECIP_1;
    endcase
    return r;
  endfunction

endpackage

// File: sv/lrcm_front.sv
// Front end: accepts input frames and tags the first one after reset as a priming frame.
module lrcm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lrcm_pkg::frame_t  in_frame,
  output logic              push_valid,
  input  logic              push_ready,
  output lrcm_pkg::job_t    push_data
);
  import lrcm_pkg::*;

  logic have_prev_r;
  logic have_prev_nxt;

  // Straight pass into the queue; classification rides along
  assign in_ready        = push_ready;
  assign push_valid      = in_valid;
  assign push_data.prime = ~have_prev_r;
  assign push_data.frame = in_frame;

  // First transfer after reset primes the interpolator
  always_comb begin
    have_prev_nxt = have_prev_r;
    if (in_valid && push_ready) begin
      have_prev_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
    end
  end

endmodule

// File: sv/lrcm_queue.sv
// Short FIFO of classified frames between the front end and the interpolation back end.
module lrcm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  lrcm_pkg::job_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output lrcm_pkg::job_t  pop_data
);
  import lrcm_pkg::*;

  job_t                 q_mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (cnt_r != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = q_mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/lrcm_back.sv
// Back end: phase sequencer, per-channel interpolation lanes, channel map and output register.
module lrcm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  lrcm_pkg::cfg_t   cfg,
  input  logic             q_valid,
  output logic             q_pop,
  input  lrcm_pkg::job_t   q_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lrcm_pkg::frame_t out_frame,
  output logic             out_last
);
  import lrcm_pkg::*;

  bk_state_t               state_r, state_nxt;
  logic [PHASE_BITS-1:0]   phase_r, phase_nxt;
  logic [RUN_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;

  frame_t                  prev_r;
  logic signed [PROD_BITS-1:0] prod_r [MAX_CH];
  logic signed [PROD_BITS-1:0] prod_nxt [MAX_CH];
  frame_t                  mix_r, mix_nxt;
  logic signed [SUM_BITS-1:0] sum_r, sum_nxt;
  logic [DIVP_BITS-1:0]    divp_r, divp_nxt;
  logic                    neg_r;
  frame_t                  out_frame_r, map_frame;
  logic                    out_last_r;

  logic                    prev_upd;
  logic                    out_load;
  logic [PHASE_BITS:0]     phase_sum;
  logic [PHASE_BITS-1:0]   phase_step;
  logic [RUN_CNT_BITS-1:0] cnt_inc;
  logic                    run_more;
  logic [SAMPLE_BITS-1:0]  avg;

  // Phase advance with saturation, and the loop test for the next result
  assign phase_sum  = {1'b0, phase_r} + {1'b0, cfg.step};
  assign phase_step = phase_sum[PHASE_BITS] ? PHASE_MAX : phase_sum[PHASE_BITS-1:0];
  assign cnt_inc    = cnt_r + 1'b1;
  assign run_more   = (phase_step < PHASE_ONE) && (cnt_inc != RUN_CNT_BITS'(RESULT_CAP));
  assign out_load   = (state_r == BK_OUT) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    prev_upd  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_data.prime) begin
            q_pop    = 1'b1;
            prev_upd = 1'b1;
          end else if (phase_r >= PHASE_ONE) begin
            // no output for this frame
            q_pop     = 1'b1;
            prev_upd  = 1'b1;
            phase_nxt = phase_r - PHASE_ONE;
          end else begin
            cnt_nxt   = '0;
            state_nxt = BK_MUL;
          end
        end
      end
      BK_MUL: state_nxt = BK_MIX;
      BK_MIX: state_nxt = BK_SUM;
      BK_SUM: state_nxt = BK_DIV;
      BK_DIV: state_nxt = BK_OUT;
      BK_OUT: begin
        if (out_load) begin
          cnt_nxt = cnt_inc;
          if (run_more) begin
            phase_nxt = phase_step;
            state_nxt = BK_MUL;
          end else begin
            // end of run: drop one period, floor at zero when the cap cut it short
            phase_nxt = (phase_step >= PHASE_ONE) ? phase_step - PHASE_ONE : '0;
            q_pop     = 1'b1;
            prev_upd  = 1'b1;
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      phase_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Lane products: (current - previous) * fraction
  always_comb begin
    logic signed [DIFF_BITS-1:0]     diff;
    logic signed [PHASE_FRAC_BITS:0] frac_s;
    frac_s = $signed({1'b0, phase_r[PHASE_FRAC_BITS-1:0]});
    for (int c = 0; c < MAX_CH; c++) begin
      diff = DIFF_BITS'($signed(q_data.frame[c])) - DIFF_BITS'($signed(prev_r[c]));
      prod_nxt[c] = PROD_BITS'(diff) * PROD_BITS'(frac_s);
    end
  end

  // Floor shift and add back the previous sample; unused inputs read as zero
  always_comb begin
    logic signed [PROD_BITS-1:0] shifted;
    for (int c = 0; c < MAX_CH; c++) begin
      shifted    = prod_r[c] >>> PHASE_FRAC_BITS;
      mix_nxt[c] = (c < int'(cfg.nin)) ? prev_r[c] + shifted[SAMPLE_BITS-1:0] : '0;
    end
  end

  // Channel sum for the mono downmix
  always_comb begin
    logic signed [SUM_BITS-1:0] acc;
    acc = '0;
    for (int c = 0; c < MAX_CH; c++) begin
      acc = acc + SUM_BITS'($signed(mix_r[c]));
    end
    sum_nxt = acc;
  end

  // Magnitude times reciprocal of the input count
  always_comb begin
    logic [SUM_BITS-1:0] mag;
    mag      = sum_r[SUM_BITS-1] ? SUM_BITS'(-sum_r) : sum_r;
    divp_nxt = DIVP_BITS'(mag) * DIVP_BITS'(recip(cfg.nin));
  end

  // Quotient with the sign restored gives truncation toward zero
  always_comb begin
    logic [SUM_BITS-1:0] quot;
    logic [SUM_BITS-1:0] sgn_quot;
    quot     = divp_r[DIV_SHIFT +: SUM_BITS];
    sgn_quot = neg_r ? SUM_BITS'(-quot) : quot;
    avg      = sgn_quot[SAMPLE_BITS-1:0];
  end

  // Channel map
  always_comb begin
    for (int c = 0; c < MAX_CH; c++) begin
      if (cfg.nin == cfg.nout) begin
        map_frame[c] = mix_r[c];
      end else if (cfg.nin == CH_CNT_BITS'(1)) begin
        map_frame[c] = (c < int'(cfg.nout)) ? mix_r[0] : '0;
      end else if (cfg.nout == CH_CNT_BITS'(1)) begin
        map_frame[c] = (c == 0) ? avg : '0;
      end else begin
        map_frame[c] = (c < int'(cfg.nout)) ? mix_r[c] : '0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (prev_upd) begin
      prev_r <= q_data.frame;
    end
    if (state_r == BK_MUL) begin
      for (int c = 0; c < MAX_CH; c++) begin
        prod_r[c] <= prod_nxt[c];
      end
    end
    if (state_r == BK_MIX) begin
      mix_r <= mix_nxt;
    end
    if (state_r == BK_SUM) begin
      sum_r <= sum_nxt;
    end
    if (state_r == BK_DIV) begin
      divp_r <= divp_nxt;
      neg_r  <= sum_r[SUM_BITS-1];
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_frame_r <= map_frame;
      out_last_r  <= ~run_more;
    end
  end

  assign out_valid = out_valid_r;
  assign out_frame = out_frame_r;
  assign out_last  = out_last_r;

  // Checks
  a_mul_phase_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_MUL) |-> (phase_r < PHASE_ONE))
    else $error("interpolation started with phase at or above one");

  a_run_under_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> (cnt_r < RUN_CNT_BITS'(RESULT_CAP)))
    else $error("run count reached the cap while still running");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !run_more) |=> (state_r == BK_IDLE && out_valid_r && out_last_r))
    else $error("final frame of a run did not return the sequencer to idle");

endmodule

// File: sv/linear_resampler_channel_map.sv
// Top level of the linear resampler with channel map: config registers, front, queue, back.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  input   | in_valid / in_ready    | in_ch0..in_ch7, signed Q1.23
//  output  | out_valid / out_ready  | out_ch0..out_ch7, out_last_of_run
//  config  | cfg_we (no wait)       | cfg_index, cfg_wdata
//
//  Each output frame passes through the back-end sequencer steps product, mix, sum,
//  reciprocal multiply and map/load in turn; an input frame produces at most 16 output
//  frames, and a priming or no-output frame produces none.
//  Reset: step 1.0, two channels in and out, phase zero, queue empty, no previous frame.
//  A stalled output holds the sequencer; the two-entry queue keeps taking input until full.
module linear_resampler_channel_map (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [lrcm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [lrcm_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [lrcm_pkg::SAMPLE_BITS-1:0] in_ch0,
  input  logic signed [lrcm_pkg::SAMPLE_BITS-1:0] in_ch1,
  input  logic signed [lrcm_pkg::SAMPLE_BITS-1:0] in_ch2,
  input  logic signed [lrcm_pkg::SAMPLE_BITS-1:0] in_ch3,
  input  logic signed [lrcm_pkg::SAMPLE_BITS-1:0] in_ch4,
  input  logic signed [lrcm_pkg::SAMPLE_BITS-1:0] in_ch5,
  input  logic signed [lrcm_pkg::SAMPLE_BITS-1:0] in_ch6,
  input  logic signed [lrcm_pkg::SAMPLE_BITS-1:0] in_ch7,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [lrcm_pkg::SAMPLE_BITS-1:0] out_ch0,
  output logic signed [lrcm_pkg::SAMPLE_BITS-1:0] out_ch1,
  output logic signed [lrcm_pkg::SAMPLE_BITS-1:0] out_ch2,
  output logic signed [lrcm_pkg::SAMPLE_BITS-1:0] out_ch3,
  output logic signed [lrcm_pkg::SAMPLE_BITS-1:0] out_ch4,
  output logic signed [lrcm_pkg::SAMPLE_BITS-1:0] out_ch5,
  output logic signed [lrcm_pkg::SAMPLE_BITS-1:0] out_ch6,
  output logic signed [lrcm_pkg::SAMPLE_BITS-1:0] out_ch7,
  output logic                                   out_last_of_run
);
  import lrcm_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  frame_t in_frame;
  frame_t out_frame;
  logic   push_valid, push_ready;
  job_t   push_data;
  logic   pop_valid, pop_ready;
  job_t   pop_data;

  // Config registers; channel counts are stored already clamped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_RATIO:   cfg_nxt.step = cfg_wdata;
        CFG_IN_CHANNELS:  cfg_nxt.nin  = clamp_count(cfg_wdata[CH_CNT_BITS-1:0]);
        CFG_OUT_CHANNELS: cfg_nxt.nout = clamp_count(cfg_wdata[CH_CNT_BITS-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step <= STEP_RESET;
      cfg_r.nin  <= CH_RESET;
      cfg_r.nout <= CH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_frame[0] = in_ch0;
  assign in_frame[1] = in_ch1;
  assign in_frame[2] = in_ch2;
  assign in_frame[3] = in_ch3;
  assign in_frame[4] = in_ch4;
  assign in_frame[5] = in_ch5;
  assign in_frame[6] = in_ch6;
  assign in_frame[7] = in_ch7;

  lrcm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_frame   (in_frame),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lrcm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lrcm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (pop_valid),
    .q_pop     (pop_ready),
    .q_data    (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_frame (out_frame),
    .out_last  (out_last_of_run)
  );

  assign out_ch0 = $signed(out_frame[0]);
  assign out_ch1 = $signed(out_frame[1]);
  assign out_ch2 = $signed(out_frame[2]);
  assign out_ch3 = $signed(out_frame[3]);
  assign out_ch4 = $signed(out_frame[4]);
  assign out_ch5 = $signed(out_frame[5]);
  assign out_ch6 = $signed(out_frame[6]);
  assign out_ch7 = $signed(out_frame[7]);

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for linear_resampler_channel_map: stimulus, predictor, checks.
module tb;
  import lrcm_pkg::*;

  localparam int LIMIT_CYCLES  = 1_500_000;
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_FRAMES = 360;
  localparam int MAX_REPORTS   = 40;
  localparam logic [SAMPLE_BITS-1:0] SMP_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0] SMP_MIN = 24'h800000;

  // One expected output frame
  typedef struct packed {
    frame_t ch;
    logic   last;
  } out_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_BITS-1:0] in_ch0 = '0, in_ch1 = '0, in_ch2 = '0, in_ch3 = '0;
  logic signed [SAMPLE_BITS-1:0] in_ch4 = '0, in_ch5 = '0, in_ch6 = '0, in_ch7 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_ch0, out_ch1, out_ch2, out_ch3;
  logic signed [SAMPLE_BITS-1:0] out_ch4, out_ch5, out_ch6, out_ch7;
  logic out_last_of_run;

  linear_resampler_channel_map uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_ch0(in_ch0), .in_ch1(in_ch1), .in_ch2(in_ch2), .in_ch3(in_ch3),
    .in_ch4(in_ch4), .in_ch5(in_ch5), .in_ch6(in_ch6), .in_ch7(in_ch7),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_ch0(out_ch0), .out_ch1(out_ch1), .out_ch2(out_ch2), .out_ch3(out_ch3),
    .out_ch4(out_ch4), .out_ch5(out_ch5), .out_ch6(out_ch6), .out_ch7(out_ch7),
    .out_last_of_run(out_last_of_run)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state and register copies
  frame_t                 held_frame = '0;
  logic [PHASE_BITS-1:0]  phase_acc = '0;
  bit                     primed = 1'b0;
  logic [PHASE_BITS-1:0]  step_reg = PHASE_ONE;
  logic [CH_CNT_BITS-1:0] nin_reg = CH_RESET;
  logic [CH_CNT_BITS-1:0] nout_reg = CH_RESET;

  frame_t     frame_q[$];
  out_frame_t want_q[$];

  int errors = 0;
  int frames_sent = 0;
  int frames_checked = 0;
  int phases_run = 0;
  int rand_frames = 0;
  int cycles = 0;

  // Handshake pacing
  frame_t tx_frame = '0;
  int tx_gap = 0, tx_quiet = 0;
  int rx_gap = 0, rx_quiet = 0;
  int hold_left = 0, hold_req = 0, hold_seen = 0;

  out_frame_t seen, due;
  frame_t     seen_ch, due_ch;

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Mostly no gap, some short, a few long; now and then a quiet stretch with none
  task automatic pick_gap(inout int quiet_left, output int gap);
    int roll;
    roll = $urandom_range(0, 99);
    gap = 0;
    if (quiet_left > 0) begin
      quiet_left--;
    end else if (roll < 3) begin
      quiet_left = $urandom_range(20, 80);
    end else if (roll < 55) begin
      gap = 0;
    end else if (roll < 88) begin
      gap = $urandom_range(1, 3);
    end else if (roll < 97) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(20, 60);
    end
  endtask

  // Interpolate and channel-map one input frame, queue the frames it should produce
  task automatic resample_frame(input frame_t cur);
    longint mixed [MAX_CH];
    longint mapped [MAX_CH];
    longint prev_s, cur_s, ch_sum;
    logic [PHASE_BITS:0] next_phase;
    frame_t ofr;
    out_frame_t res;
    int nin, nout, made;
    nin  = (nin_reg == 0) ? 1 : (nin_reg > MAX_CH) ? MAX_CH : int'(nin_reg);
    nout = (nout_reg == 0) ? 1 : (nout_reg > MAX_CH) ? MAX_CH : int'(nout_reg);
    // very first frame only primes the history
    if (!primed) begin
      held_frame = cur;
      primed = 1'b1;
      return;
    end
    made = 0;
    while (phase_acc < PHASE_ONE && made < RESULT_CAP) begin
      // prev + floor((cur - prev) * phase / 2^16) on the used inputs
      for (int c = 0; c < MAX_CH; c++) begin
        mixed[c] = 0;
        mapped[c] = 0;
        if (c < nin) begin
          prev_s = $signed(held_frame[c]);
          cur_s = $signed(cur[c]);
          mixed[c] = prev_s + (((cur_s - prev_s) * longint'(phase_acc)) >>> PHASE_FRAC_BITS);
        end
      end
      // channel map
      if (nin == nout) begin
        for (int c = 0; c < nin; c++) mapped[c] = mixed[c];
      end else if (nin == 1) begin
        for (int c = 0; c < nout; c++) mapped[c] = mixed[0];
      end else if (nout == 1) begin
        ch_sum = 0;
        for (int c = 0; c < nin; c++) ch_sum += mixed[c];
        mapped[0] = ch_sum / longint'(nin);
      end else begin
        for (int c = 0; c < MAX_CH; c++)
          if (c < nin && c < nout) mapped[c] = mixed[c];
      end
      for (int c = 0; c < MAX_CH; c++) ofr[c] = SAMPLE_BITS'(mapped[c]);
      made++;
      next_phase = {1'b0, phase_acc} + {1'b0, step_reg};
      phase_acc = (next_phase > PHASE_MAX) ? PHASE_MAX : next_phase[PHASE_BITS-1:0];
      // last of run when the loop is about to stop
      res = {ofr, (phase_acc >= PHASE_ONE || made >= RESULT_CAP)};
      want_q.push_back(res);
    end
    phase_acc = (phase_acc >= PHASE_ONE) ? phase_acc - PHASE_ONE : '0;
    held_frame = cur;
  endtask

  function automatic frame_t flat(input logic [SAMPLE_BITS-1:0] v);
    return {MAX_CH{v}};
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    int roll;
    for (int c = 0; c < MAX_CH; c++) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) f[c] = SMP_MAX;
      else if (roll == 1) f[c] = SMP_MIN;
      else if (roll == 2) f[c] = SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
      else f[c] = SAMPLE_BITS'($urandom);
    end
    return f;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STEP_RATIO:   step_reg = data;
      CFG_IN_CHANNELS:  nin_reg = data[CH_CNT_BITS-1:0];
      CFG_OUT_CHANNELS: nout_reg = data[CH_CNT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Counts go out with junk in the unused upper data bits
  task automatic apply_config(input logic [PHASE_BITS-1:0] st,
                              input logic [CH_CNT_BITS-1:0] ci, co);
    logic [CFG_DATA_BITS-1:0] w;
    write_reg(CFG_STEP_RATIO, st);
    w = CFG_DATA_BITS'($urandom);
    w[CH_CNT_BITS-1:0] = ci;
    write_reg(CFG_IN_CHANNELS, w);
    w = CFG_DATA_BITS'($urandom);
    w[CH_CNT_BITS-1:0] = co;
    write_reg(CFG_OUT_CHANNELS, w);
    phases_run++;
    @(negedge clk);
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      frame_q.push_back(rand_frame());
      rand_frames++;
    end
  endtask

  // Everything accepted and answered, then let trailing no-output frames finish
  task automatic wait_drained();
    @(negedge clk);
    while (frame_q.size() != 0 || in_valid || want_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: valid held until the transfer, then a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        resample_frame(tx_frame);
        frames_sent++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          in_valid <= 1'b0;
          tx_gap--;
        end else if (frame_q.size() > 0) begin
          tx_frame = frame_q.pop_front();
          {in_ch7, in_ch6, in_ch5, in_ch4, in_ch3, in_ch2, in_ch1, in_ch0} <= tx_frame;
          in_valid <= 1'b1;
          pick_gap(tx_quiet, tx_gap);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output stall on request, while frames are still expected
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen && want_q.size() > 0) begin
      hold_left <= LONG_HOLD;
      hold_seen <= hold_req;
    end
  end

  // Output monitor and ready pacing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {out_ch7, out_ch6, out_ch5, out_ch4, out_ch3, out_ch2, out_ch1, out_ch0,
                out_last_of_run};
        seen_ch = seen.ch;
        if (want_q.size() == 0) begin
          report_error($sformatf("output frame with none expected, ch0=%0d last=%0b",
                                 out_ch0, out_last_of_run));
        end else begin
          due = want_q.pop_front();
          due_ch = due.ch;
          for (int c = 0; c < MAX_CH; c++)
            if (seen_ch[c] !== due_ch[c])
              report_error($sformatf("output frame %0d ch%0d: got %0d, expected %0d",
                                     frames_checked, c, $signed(seen_ch[c]),
                                     $signed(due_ch[c])));
          if (seen.last !== due.last)
            report_error($sformatf("output frame %0d last_of_run: got %0b, expected %0b",
                                   frames_checked, seen.last, due.last));
          frames_checked++;
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
        pick_gap(rx_quiet, rx_gap);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("watchdog expired after %0d cycles, %0d output frames still due",
               cycles, want_q.size());
      $display("linear_resampler_channel_map verification failed");
      $finish;
    end
  end

  initial begin
    frame_t f;
    int kind, n;
    logic [PHASE_BITS-1:0] st;
    logic [CH_CNT_BITS-1:0] ci, co;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: priming frame, then full-scale steps at unit ratio
    frame_q.push_back(flat('0));
    frame_q.push_back(flat(SMP_MAX));
    frame_q.push_back(flat(SMP_MIN));
    f = flat(SMP_MAX);
    for (int c = 1; c < MAX_CH; c += 2) f[c] = SMP_MIN;
    frame_q.push_back(f);
    frame_q.push_back(flat(SMP_MIN));
    wait_drained();

    // Fractional phase: floor rounding on negative and tiny differences
    apply_config(21'h05555, 4'd8, 4'd8);
    frame_q.push_back(flat(SMP_MAX));
    frame_q.push_back(flat(SMP_MIN));
    frame_q.push_back(flat('1));
    frame_q.push_back(flat(24'd1));
    for (int c = 0; c < MAX_CH; c++) f[c] = SAMPLE_BITS'(c * 1000 - 3000);
    frame_q.push_back(f);
    frame_q.push_back(flat(SMP_MAX));
    wait_drained();

    // Downmix to mono, truncation toward zero
    apply_config(21'h08000, 4'd4, 4'd1);
    f = flat('1);
    f[3] = '0;
    frame_q.push_back(f);
    f = flat(24'd1);
    f[3] = '0;
    frame_q.push_back(f);
    frame_q.push_back(flat(SMP_MIN));
    frame_q.push_back(flat(SMP_MAX));
    wait_drained();

    // Zero step hits the run cap; zero and oversized counts clamp
    apply_config('0, 4'd0, 4'd15);
    frame_q.push_back(flat(SMP_MIN));
    frame_q.push_back(rand_frame());
    wait_drained();

    // Largest step saturates the phase
    apply_config('1, 4'd15, 4'd0);
    frame_q.push_back(rand_frame());
    frame_q.push_back(rand_frame());
    frame_q.push_back(rand_frame());
    wait_drained();

    // Lowest step in range with a long output stall: block fills and back-pressures
    apply_config(21'd4096, 4'd8, 4'd8);
    push_random(12);
    hold_req++;
    wait_drained();

    // Highest step in range, mono fan-out
    apply_config(21'd1048576, 4'd1, 4'd8);
    push_random(40);
    wait_drained();

    // Random settings
    while (rand_frames < RANDOM_FRAMES) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) st = '0;
      else if (kind < 5) st = PHASE_BITS'($urandom_range(1000, 16383));
      else if (kind < 14) st = PHASE_BITS'($urandom_range(16384, 131072));
      else if (kind < 18) st = PHASE_BITS'($urandom_range(131073, 1048576));
      else st = PHASE_BITS'($urandom_range(1048577, 2097151));
      ci = CH_CNT_BITS'($urandom_range(0, 15));
      co = CH_CNT_BITS'($urandom_range(0, 15));
      kind = $urandom_range(0, 9);
      if (kind < 3) co = ci;
      else if (kind < 5) ci = 4'd1;
      else if (kind < 7) co = 4'd1;
      n = (st < 21'd16384) ? 8 : 24;
      if (n > RANDOM_FRAMES - rand_frames) n = RANDOM_FRAMES - rand_frames;
      apply_config(st, ci, co);
      push_random(n);
      if (phases_run == 10) hold_req++;
      wait_drained();
    end

    $display("%0d input frames over %0d register settings, %0d output frames compared",
             frames_sent, phases_run, frames_checked);
    $display("steps from zero to full scale, clamped counts, mono fan-out and downmix, stalls");
    if (errors == 0) begin
      $display("linear_resampler_channel_map verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("linear_resampler_channel_map verification failed");
    end
    $finish;
  end

endmodule
